@@ hdl/ssc_pkg.sv @@
// shared constants and types for the segment closest-points pipeline
package ssc_pkg;

    // default coordinate and fraction widths
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // width of the zero tolerance register
    localparam int TOL_BITS = 16;

    // width of the case code
    localparam int CASE_BITS = 2;

    // which solution path a word took
    typedef enum logic [CASE_BITS-1:0] {
        CASE_GENERAL = 2'd0,
        CASE_BOTH    = 2'd1,
        CASE_FIRST   = 2'd2,
        CASE_SECOND  = 2'd3
    } t_case;

endpackage

@@ hdl/ssc_cfg_if.sv @@
// configuration write channel carrying the zero tolerance
interface ssc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::TOL_BITS-1:0]  zero_tolerance;

    modport source(output valid, output zero_tolerance, input ready);
    modport sink(input valid, input zero_tolerance, output ready);
endinterface

@@ hdl/ssc_in_if.sv @@
// input channel carrying the four segment endpoints
interface ssc_in_if #(
    parameter int COORD_BITS = ssc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_start_z;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg1_end_z;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_start_z;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;
    logic signed [COORD_BITS-1:0] seg2_end_z;

    modport source(
        output valid, input ready,
        output seg1_start_x, output seg1_start_y, output seg1_start_z,
        output seg1_end_x, output seg1_end_y, output seg1_end_z,
        output seg2_start_x, output seg2_start_y, output seg2_start_z,
        output seg2_end_x, output seg2_end_y, output seg2_end_z
    );
    modport sink(
        input valid, output ready,
        input seg1_start_x, input seg1_start_y, input seg1_start_z,
        input seg1_end_x, input seg1_end_y, input seg1_end_z,
        input seg2_start_x, input seg2_start_y, input seg2_start_z,
        input seg2_end_x, input seg2_end_y, input seg2_end_z
    );
endinterface

@@ hdl/ssc_out_if.sv @@
// output channel carrying the closest points and their parameters
interface ssc_out_if #(
    parameter int COORD_BITS    = ssc_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = ssc_pkg::FRACTION_BITS_DEF
);
    logic                                      valid;
    logic                                      ready;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near1_x;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near1_y;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near1_z;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near2_x;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near2_y;
    logic signed [COORD_BITS+FRACTION_BITS-1:0] near2_z;
    logic [FRACTION_BITS:0]                     param_first;
    logic [FRACTION_BITS:0]                     param_second;
    logic [ssc_pkg::CASE_BITS-1:0]              case_code;

    modport source(
        output valid, input ready,
        output near1_x, output near1_y, output near1_z,
        output near2_x, output near2_y, output near2_z,
        output param_first, output param_second, output case_code
    );
    modport sink(
        input valid, output ready,
        input near1_x, input near1_y, input near1_z,
        input near2_x, input near2_y, input near2_z,
        input param_first, input param_second, input case_code
    );
endinterface

@@ hdl/segment_segment_closest_points.sv @@
// top level: closest points between two 3d segments, fully pipelined
//
//  channel   | dir | handshake    | word
//  ----------+-----+--------------+------------------------------------------
//  i_cfg     | in  | valid/ready  | zero_tolerance, always ready
//  i_in      | in  | valid/ready  | start and end points of both segments
//  o_out     | out | valid/ready  | near points, t, s, case code
//
//  one word per cycle while the output is not stalled; most of the depth lies
//  in three chained ratio units of one bit per stage.
//  reset clears the valid bits and the tolerance; the pipeline is empty.
//  the whole pipeline advances together; a stalled output word freezes it
//  and input ready drops, so nothing is lost or repeated.
module segment_segment_closest_points #(
    parameter int COORD_BITS    = ssc_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = ssc_pkg::FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_cfg_if.sink   i_cfg,
    ssc_in_if.sink    i_in,
    ssc_out_if.source o_out
);
    localparam int CB  = COORD_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int DB  = CB + 1;
    localparam int DOT = 2 * DB + 2;
    localparam int H   = DOT / 2;
    localparam int HH  = DOT - H;
    localparam int PLW = H + 1 + DOT;
    localparam int PHW = HH + DOT;
    localparam int PRW = 2 * DOT;
    localparam int PW  = PRW + 1;
    localparam int PB  = FB + 1;
    localparam int QW  = DOT + PB + 1;
    localparam int N2W = QW + 1;
    localparam int PTW = CB + FB;
    localparam int XW  = DB + PB + 2;

    typedef struct packed {
        logic [2:0][CB-1:0] s1;
        logic [2:0][CB-1:0] s2;
        logic [2:0][DB-1:0] ab;
        logic [2:0][DB-1:0] cd;
        logic [2:0][DB-1:0] ca;
        logic [DOT-1:0]     a;
        logic [DOT-1:0]     c;
        logic [DOT-1:0]     d;
        logic [DOT-1:0]     e;
        logic [DOT-1:0]     f;
        ssc_pkg::t_case     kind;
    } t_ctx;

    typedef struct packed {
        t_ctx          ctx;
        logic [PB-1:0] p1;
    } t_ctx2;

    typedef struct packed {
        t_ctx          ctx;
        logic [PB-1:0] p1;
        logic [PB-1:0] p2;
    } t_ctx3;

    localparam int SW1 = $bits(t_ctx);
    localparam int SW2 = $bits(t_ctx2);
    localparam int SW3 = $bits(t_ctx3);

    logic                          en;
    logic [ssc_pkg::TOL_BITS-1:0]  r_tol;

    // tolerance register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.zero_tolerance;
        end
    end

    // global advance
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // stage 1: edge vectors
    logic  r_v1;
    t_ctx  r_c1;
    t_ctx  n_c1;
    always_comb begin
        logic signed [CB-1:0] s1v [3];
        logic signed [CB-1:0] e1v [3];
        logic signed [CB-1:0] s2v [3];
        logic signed [CB-1:0] e2v [3];
        s1v[0] = i_in.seg1_start_x; s1v[1] = i_in.seg1_start_y; s1v[2] = i_in.seg1_start_z;
        e1v[0] = i_in.seg1_end_x;   e1v[1] = i_in.seg1_end_y;   e1v[2] = i_in.seg1_end_z;
        s2v[0] = i_in.seg2_start_x; s2v[1] = i_in.seg2_start_y; s2v[2] = i_in.seg2_start_z;
        e2v[0] = i_in.seg2_end_x;   e2v[1] = i_in.seg2_end_y;   e2v[2] = i_in.seg2_end_z;
        n_c1 = '0;
        for (int i = 0; i < 3; i++) begin
            n_c1.s1[i] = s1v[i];
            n_c1.s2[i] = s2v[i];
            n_c1.ab[i] = DB'(e1v[i]) - DB'(s1v[i]);
            n_c1.cd[i] = DB'(e2v[i]) - DB'(s2v[i]);
            n_c1.ca[i] = DB'(s1v[i]) - DB'(s2v[i]);
        end
    end

    // stage 2: dot products
    logic  r_v2;
    t_ctx  r_c2;
    t_ctx  n_c2;
    always_comb begin
        logic signed [DB-1:0]  vab;
        logic signed [DB-1:0]  vcd;
        logic signed [DB-1:0]  vca;
        logic signed [DOT-1:0] acc_a;
        logic signed [DOT-1:0] acc_c;
        logic signed [DOT-1:0] acc_d;
        logic signed [DOT-1:0] acc_e;
        logic signed [DOT-1:0] acc_f;
        acc_a = '0; acc_c = '0; acc_d = '0; acc_e = '0; acc_f = '0;
        for (int i = 0; i < 3; i++) begin
            vab   = $signed(r_c1.ab[i]);
            vcd   = $signed(r_c1.cd[i]);
            vca   = $signed(r_c1.ca[i]);
            acc_a = acc_a + vab * vab;
            acc_c = acc_c + vca * vab;
            acc_d = acc_d + vab * vcd;
            acc_e = acc_e + vcd * vcd;
            acc_f = acc_f + vca * vcd;
        end
        n_c2   = r_c1;
        n_c2.a = acc_a;
        n_c2.c = acc_c;
        n_c2.d = acc_d;
        n_c2.e = acc_e;
        n_c2.f = acc_f;
    end

    // stage 3: degenerate checks and split partial products
    logic                  r_v3;
    t_ctx                  r_c3;
    t_ctx                  n_c3;
    logic signed [PLW-1:0] r_pl [4];
    logic signed [PHW-1:0] r_ph [4];
    logic signed [PLW-1:0] n_pl [4];
    logic signed [PHW-1:0] n_ph [4];
    always_comb begin
        logic signed [DOT-1:0] tol_d;
        logic signed [DOT-1:0] xs [4];
        logic signed [DOT-1:0] ys [4];
        logic                  deg1;
        logic                  deg2;
        tol_d = DOT'(r_tol);
        deg1  = $signed(r_c2.a) <= tol_d;
        deg2  = $signed(r_c2.e) <= tol_d;
        n_c3  = r_c2;
        case ({deg1, deg2})
            2'b11:   n_c3.kind = ssc_pkg::CASE_BOTH;
            2'b10:   n_c3.kind = ssc_pkg::CASE_FIRST;
            2'b01:   n_c3.kind = ssc_pkg::CASE_SECOND;
            default: n_c3.kind = ssc_pkg::CASE_GENERAL;
        endcase
        // a*e, d*d, a*f, c*d
        xs[0] = r_c2.a; ys[0] = r_c2.e;
        xs[1] = r_c2.d; ys[1] = r_c2.d;
        xs[2] = r_c2.a; ys[2] = r_c2.f;
        xs[3] = r_c2.c; ys[3] = r_c2.d;
        for (int j = 0; j < 4; j++) begin
            n_pl[j] = $signed({1'b0, xs[j][H-1:0]}) * ys[j];
            n_ph[j] = $signed(xs[j][DOT-1:H]) * ys[j];
        end
    end

    // stage 4: recombine partial products
    logic                  r_v4;
    t_ctx                  r_c4;
    logic signed [PRW-1:0] r_pr [4];
    logic signed [PRW-1:0] n_pr [4];
    always_comb begin
        logic signed [PRW-1:0] eh;
        logic signed [PRW-1:0] el;
        for (int j = 0; j < 4; j++) begin
            eh      = r_ph[j];
            el      = r_pl[j];
            n_pr[j] = (eh <<< H) + el;
        end
    end

    // stage 5: determinant and numerator
    logic                 r_v5;
    t_ctx                 r_c5;
    logic signed [PW-1:0] r_det;
    logic signed [PW-1:0] r_num;
    logic signed [PW-1:0] n_det;
    logic signed [PW-1:0] n_num;
    always_comb begin
        logic signed [PW-1:0] p0;
        logic signed [PW-1:0] p1;
        logic signed [PW-1:0] p2;
        logic signed [PW-1:0] p3;
        p0    = r_pr[0];
        p1    = r_pr[1];
        p2    = r_pr[2];
        p3    = r_pr[3];
        n_det = p0 - p1;
        n_num = p2 - p3;
    end

    // first ratio operand select
    logic signed [PW-1:0] d1_n;
    logic signed [PW-1:0] d1_d;
    always_comb begin
        logic signed [PW-1:0] tol_p;
        logic signed [PW-1:0] ax;
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] ex;
        logic signed [PW-1:0] fx;
        tol_p = PW'(r_tol);
        ax    = $signed(r_c5.a);
        cx    = $signed(r_c5.c);
        ex    = $signed(r_c5.e);
        fx    = $signed(r_c5.f);
        case (r_c5.kind)
            ssc_pkg::CASE_GENERAL: begin
                if (r_det <= tol_p) begin
                    d1_n = fx;
                    d1_d = ex;
                end else begin
                    d1_n = r_num;
                    d1_d = r_det;
                end
            end
            ssc_pkg::CASE_FIRST: begin
                d1_n = fx;
                d1_d = ex;
            end
            ssc_pkg::CASE_SECOND: begin
                d1_n = -cx;
                d1_d = ax;
            end
            default: begin
                d1_n = '0;
                d1_d = '0;
            end
        endcase
    end

    logic           d1_v;
    logic [PB-1:0]  d1_q;
    logic [SW1-1:0] d1_side;
    t_ctx           d1_ctx;

    ssc_div #(.W(PW), .F(FB), .SW(SW1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_num   (d1_n),
        .i_den   (d1_d),
        .i_side  (r_c5),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );
    assign d1_ctx = t_ctx'(d1_side);

    // stage 7: d times first parameter
    logic                 r_v7;
    t_ctx2                r_c7;
    logic signed [QW-1:0] r_prod1;
    logic signed [QW-1:0] n_prod1;
    assign n_prod1 = $signed(d1_ctx.d) * $signed({1'b0, d1_q});

    // recomputed t operands
    logic signed [N2W-1:0] d2_n;
    logic signed [N2W-1:0] d2_d;
    always_comb begin
        logic signed [N2W-1:0] px;
        logic signed [N2W-1:0] cx;
        logic signed [N2W-1:0] ax;
        px   = r_prod1;
        cx   = $signed(r_c7.ctx.c);
        ax   = $signed(r_c7.ctx.a);
        d2_n = px - (cx <<< FB);
        d2_d = ax <<< FB;
    end

    logic           d2_v;
    logic [PB-1:0]  d2_q;
    logic [SW2-1:0] d2_side;
    t_ctx2          d2_ctx;

    ssc_div #(.W(N2W), .F(FB), .SW(SW2)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_num   (d2_n),
        .i_den   (d2_d),
        .i_side  (r_c7),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );
    assign d2_ctx = t_ctx2'(d2_side);

    // stage 8: d times recomputed t
    logic                 r_v8;
    t_ctx3                r_c8;
    logic signed [QW-1:0] r_prod2;
    logic signed [QW-1:0] n_prod2;
    t_ctx3                n_c8;
    assign n_prod2 = $signed(d2_ctx.ctx.d) * $signed({1'b0, d2_q});
    always_comb begin
        n_c8.ctx = d2_ctx.ctx;
        n_c8.p1  = d2_ctx.p1;
        n_c8.p2  = d2_q;
    end

    // recomputed s operands
    logic signed [N2W-1:0] d3_n;
    logic signed [N2W-1:0] d3_d;
    always_comb begin
        logic signed [N2W-1:0] px;
        logic signed [N2W-1:0] fx;
        logic signed [N2W-1:0] ex;
        px   = r_prod2;
        fx   = $signed(r_c8.ctx.f);
        ex   = $signed(r_c8.ctx.e);
        d3_n = (fx <<< FB) + px;
        d3_d = ex <<< FB;
    end

    logic           d3_v;
    logic [PB-1:0]  d3_q;
    logic [SW3-1:0] d3_side;
    t_ctx3          d3_ctx;

    ssc_div #(.W(N2W), .F(FB), .SW(SW3)) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v8),
        .i_num   (d3_n),
        .i_den   (d3_d),
        .i_side  (r_c8),
        .o_valid (d3_v),
        .o_quo   (d3_q),
        .o_side  (d3_side)
    );
    assign d3_ctx = t_ctx3'(d3_side);

    // final parameter select and point placement
    logic [PB-1:0]         n_t;
    logic [PB-1:0]         n_s;
    logic [PTW-1:0]        n_near1 [3];
    logic [PTW-1:0]        n_near2 [3];
    always_comb begin
        logic signed [XW-1:0] org;
        logic signed [XW-1:0] stp;
        case (d3_ctx.ctx.kind)
            ssc_pkg::CASE_GENERAL: begin
                n_t = d3_ctx.p2;
                n_s = d3_q;
            end
            ssc_pkg::CASE_FIRST: begin
                n_t = '0;
                n_s = d3_ctx.p1;
            end
            ssc_pkg::CASE_SECOND: begin
                n_t = d3_ctx.p1;
                n_s = '0;
            end
            default: begin
                n_t = '0;
                n_s = '0;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            org        = $signed(d3_ctx.ctx.s1[i]);
            stp        = $signed(d3_ctx.ctx.ab[i]) * $signed({1'b0, n_t});
            stp        = (org <<< FB) + stp;
            n_near1[i] = stp[PTW-1:0];
            org        = $signed(d3_ctx.ctx.s2[i]);
            stp        = $signed(d3_ctx.ctx.cd[i]) * $signed({1'b0, n_s});
            stp        = (org <<< FB) + stp;
            n_near2[i] = stp[PTW-1:0];
        end
    end

    // output register
    logic                      r_vo;
    logic [PTW-1:0]            r_near1 [3];
    logic [PTW-1:0]            r_near2 [3];
    logic [PB-1:0]             r_t;
    logic [PB-1:0]             r_s;
    ssc_pkg::t_case            r_kind;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v7 <= d1_v;
            r_v8 <= d2_v;
            r_vo <= d3_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1     <= n_c1;
            r_c2     <= n_c2;
            r_c3     <= n_c3;
            r_pl     <= n_pl;
            r_ph     <= n_ph;
            r_c4     <= r_c3;
            r_pr     <= n_pr;
            r_c5     <= r_c4;
            r_det    <= n_det;
            r_num    <= n_num;
            r_c7.ctx <= d1_ctx;
            r_c7.p1  <= d1_q;
            r_prod1  <= n_prod1;
            r_c8     <= n_c8;
            r_prod2  <= n_prod2;
            r_near1  <= n_near1;
            r_near2  <= n_near2;
            r_t      <= n_t;
            r_s      <= n_s;
            r_kind   <= d3_ctx.ctx.kind;
        end
    end

    // output word
    assign o_out.valid        = r_vo;
    assign o_out.near1_x      = r_near1[0];
    assign o_out.near1_y      = r_near1[1];
    assign o_out.near1_z      = r_near1[2];
    assign o_out.near2_x      = r_near2[0];
    assign o_out.near2_y      = r_near2[1];
    assign o_out.near2_z      = r_near2[2];
    assign o_out.param_first  = r_t;
    assign o_out.param_second = r_s;
    assign o_out.case_code    = r_kind;

endmodule

@@ hdl/ssc_div.sv @@
// pipelined clamped ratio unit, one quotient bit per stage
module ssc_div #(
    parameter int W  = 40,
    parameter int F  = ssc_pkg::FRACTION_BITS_DEF,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [F:0]          o_quo,
    output logic [SW-1:0]       o_side
);
    // capture stage, flag stage, then one stage per quotient bit
    localparam int NS = F + 2;

    logic [NS-1:0]       r_v;
    logic signed [W-1:0] r_num;
    logic signed [W-1:0] r_den;
    logic [SW-1:0]       r_side [NS];
    logic [W-1:0]        r_rem  [NS];
    logic [W-1:0]        r_dv   [NS];
    logic [F-1:0]        r_q    [NS];
    logic                r_zero [NS];
    logic                r_one  [NS];
    logic                n_zero;
    logic                n_one;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // capture operands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num     <= i_num;
            r_den     <= i_den;
            r_side[0] <= i_side;
        end
    end

    // zero and saturation checks, denominator is never negative
    always_comb begin
        n_zero = (r_den == '0) || r_num[W-1] || (r_num == '0);
        n_one  = !n_zero && (r_num >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= r_side[0];
            r_rem[1]  <= r_num;
            r_dv[1]   <= r_den;
            r_q[1]    <= '0;
            r_zero[1] <= n_zero;
            r_one[1]  <= n_one;
        end
    end

    // restoring division steps
    for (genvar k = 2; k < NS; k++) begin : g_step
        logic [W-1:0] w_sh;
        logic [W-1:0] w_df;
        logic         w_ge;

        always_comb begin
            w_sh = {r_rem[k-1][W-2:0], 1'b0};
            w_ge = (w_sh >= r_dv[k-1]);
            w_df = w_sh - r_dv[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_rem[k]  <= w_ge ? w_df : w_sh;
                r_dv[k]   <= r_dv[k-1];
                r_q[k]    <= {r_q[k-1][F-2:0], w_ge};
                r_zero[k] <= r_zero[k-1];
                r_one[k]  <= r_one[k-1];
            end
        end
    end

    // clamp to [0, 1.0]
    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_quo   = r_zero[NS-1] ? '0 :
                     r_one[NS-1]  ? {1'b1, {F{1'b0}}} :
                                    {1'b0, r_q[NS-1]};

endmodule

@@ test/segment_segment_closest_points_test.sv @@
// testbench for the segment closest-points pipeline: directed table, then random pairs
module segment_segment_closest_points_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  LATENCY      = 62;
    localparam int  ONE_Q        = 1 << ssc_pkg::FRACTION_BITS_DEF;

    typedef logic signed [15:0]  t_coord;
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        t_coord s1x, s1y, s1z, e1x, e1y, e1z;
        t_coord s2x, s2y, s2z, e2x, e2y, e2z;
    } t_seg_pair;

    typedef struct packed {
        logic [5:0][31:0] near;
        logic [16:0]      t;
        logic [16:0]      s;
        ssc_pkg::t_case   kind;
    } t_closest;

    typedef struct {
        t_seg_pair pair;
        bit        typed;
        t_closest  want;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssc_cfg_if cfg_ch();
    ssc_in_if  seg_in();
    ssc_out_if pts_out();

    segment_segment_closest_points u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (seg_in),
        .o_out  (pts_out)
    );

    t_closest    pending_q[$];
    logic [15:0] tolerance;
    int          errors    = 0;
    int          cycles    = 0;
    int          tx_idle   = 0;
    int          rx_idle   = 0;
    int          hold_left = 0;

    // clock
    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // clamp(n/d) to [0,1] as Q1.16, floor rounding
    function automatic logic [16:0] clamp_q(t_wide n, t_wide d);
        t_wide q;
        if (d == 0) return '0;
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        if (n <= 0) return '0;
        if (n >= d) return 17'(ONE_Q);
        q = (n <<< 16) / d;
        return q[16:0];
    endfunction

    function automatic t_wide dot3(t_wide u[3], t_wide v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic bit is_zero(t_wide v, logic [15:0] tol);
        t_wide mag;
        t_wide lim;
        mag = (v < 0) ? -v : v;
        lim = t_wide'(tol);
        return mag <= lim;
    endfunction

    // closest points between the two segments
    function automatic t_closest closest_points(t_seg_pair p, logic [15:0] tol);
        t_wide s1[3], s2[3], ab[3], cd[3], ca[3], ac[3];
        t_wide va, vb, vc, vd, ve, vf, det, one, tw, sw, v;
        t_closest r;
        bit deg1, deg2;
        s1 = '{p.s1x, p.s1y, p.s1z};
        s2 = '{p.s2x, p.s2y, p.s2z};
        ab = '{t_wide'(p.e1x) - p.s1x, t_wide'(p.e1y) - p.s1y, t_wide'(p.e1z) - p.s1z};
        cd = '{t_wide'(p.e2x) - p.s2x, t_wide'(p.e2y) - p.s2y, t_wide'(p.e2z) - p.s2z};
        for (int i = 0; i < 3; i++) begin
            ca[i] = s1[i] - s2[i];
            ac[i] = -ca[i];
        end
        one  = t_wide'(ONE_Q);
        r    = '0;
        deg1 = is_zero(dot3(ab, ab), tol);
        deg2 = is_zero(dot3(cd, cd), tol);
        if (deg1 && deg2) begin
            r.kind = ssc_pkg::CASE_BOTH;
        end else if (deg1) begin
            r.kind = ssc_pkg::CASE_FIRST;
            r.s    = clamp_q(dot3(ca, cd), dot3(cd, cd));
        end else if (deg2) begin
            r.kind = ssc_pkg::CASE_SECOND;
            r.t    = clamp_q(dot3(ac, ab), dot3(ab, ab));
        end else begin
            va  = dot3(ab, ab);
            vd  = dot3(ab, cd);
            vb  = -vd;
            vc  = -dot3(ca, ab);
            ve  = -dot3(cd, cd);
            vf  = -dot3(ca, cd);
            det = va * ve - vb * vd;
            r.kind = ssc_pkg::CASE_GENERAL;
            // parallel segments take s from the second equation alone
            if (!is_zero(det, tol)) r.s = clamp_q(va * vf - vc * vd, det);
            else                    r.s = clamp_q(vf, ve);
            sw  = t_wide'(r.s);
            r.t = clamp_q(vc * one - vb * sw, va * one);
            tw  = t_wide'(r.t);
            r.s = clamp_q(vf * one - vd * tw, ve * one);
        end
        tw = t_wide'(r.t);
        sw = t_wide'(r.s);
        for (int i = 0; i < 3; i++) begin
            v = s1[i] * one + ab[i] * tw;
            r.near[i] = v[31:0];
            v = s2[i] * one + cd[i] * sw;
            r.near[3 + i] = v[31:0];
        end
        return r;
    endfunction

    // expectation typed in for two fixed points, nothing solved
    function automatic t_closest points_only(int ax, int ay, int az, int bx, int by, int bz);
        t_closest r;
        r = '0;
        r.near[0] = ax * ONE_Q;
        r.near[1] = ay * ONE_Q;
        r.near[2] = az * ONE_Q;
        r.near[3] = bx * ONE_Q;
        r.near[4] = by * ONE_Q;
        r.near[5] = bz * ONE_Q;
        r.kind    = ssc_pkg::CASE_BOTH;
        return r;
    endfunction

    function automatic t_coord near_coord(t_coord c, int spread);
        return t_coord'(int'(c) + $urandom_range(0, 2 * spread) - spread);
    endfunction

    // random pair; half are shaped to reach the degenerate and parallel paths
    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        int        shape;
        int        k;
        p     = t_seg_pair'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        shape = $urandom_range(0, 7);
        if (shape >= 1) begin
            p.s1x = $urandom_range(0, 400) - 200;  p.s1y = $urandom_range(0, 400) - 200;
            p.s1z = $urandom_range(0, 400) - 200;  p.e1x = $urandom_range(0, 400) - 200;
            p.e1y = $urandom_range(0, 400) - 200;  p.e1z = $urandom_range(0, 400) - 200;
            p.s2x = $urandom_range(0, 400) - 200;  p.s2y = $urandom_range(0, 400) - 200;
            p.s2z = $urandom_range(0, 400) - 200;  p.e2x = $urandom_range(0, 400) - 200;
            p.e2y = $urandom_range(0, 400) - 200;  p.e2z = $urandom_range(0, 400) - 200;
        end
        if (shape == 2 || shape == 4) begin
            p.e1x = near_coord(p.s1x, 3);
            p.e1y = near_coord(p.s1y, 3);
            p.e1z = near_coord(p.s1z, 3);
        end
        if (shape == 3 || shape == 4) begin
            p.e2x = near_coord(p.s2x, 3);
            p.e2y = near_coord(p.s2y, 3);
            p.e2z = near_coord(p.s2z, 3);
        end
        if (shape == 5) begin
            // second segment along a multiple of the first, nearly parallel
            k = $urandom_range(0, 6) - 3;
            p.e2x = near_coord(t_coord'(p.s2x + k * (p.e1x - p.s1x)), 1);
            p.e2y = t_coord'(p.s2y + k * (p.e1y - p.s1y));
            p.e2z = t_coord'(p.s2z + k * (p.e1z - p.s1z));
        end
        return p;
    endfunction

    // receiver ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pts_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            pts_out.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            pts_out.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // result checker, sampled mid-cycle
    always @(negedge i_clk) begin
        t_closest want;
        if (i_rst_n && pts_out.valid && pts_out.ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word near1_x=%h", $realtime, pts_out.near1_x);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (pts_out.near1_x !== want.near[0]) begin
                    $display("%0t: near1_x exp %h got %h", $realtime, want.near[0], pts_out.near1_x);
                    errors++;
                end
                if (pts_out.near1_y !== want.near[1]) begin
                    $display("%0t: near1_y exp %h got %h", $realtime, want.near[1], pts_out.near1_y);
                    errors++;
                end
                if (pts_out.near1_z !== want.near[2]) begin
                    $display("%0t: near1_z exp %h got %h", $realtime, want.near[2], pts_out.near1_z);
                    errors++;
                end
                if (pts_out.near2_x !== want.near[3]) begin
                    $display("%0t: near2_x exp %h got %h", $realtime, want.near[3], pts_out.near2_x);
                    errors++;
                end
                if (pts_out.near2_y !== want.near[4]) begin
                    $display("%0t: near2_y exp %h got %h", $realtime, want.near[4], pts_out.near2_y);
                    errors++;
                end
                if (pts_out.near2_z !== want.near[5]) begin
                    $display("%0t: near2_z exp %h got %h", $realtime, want.near[5], pts_out.near2_z);
                    errors++;
                end
                if (pts_out.param_first !== want.t) begin
                    $display("%0t: param_first exp %h got %h", $realtime, want.t, pts_out.param_first);
                    errors++;
                end
                if (pts_out.param_second !== want.s) begin
                    $display("%0t: param_second exp %h got %h", $realtime, want.s,
                             pts_out.param_second);
                    errors++;
                end
                if (pts_out.case_code !== want.kind) begin
                    $display("%0t: case_code exp %0d got %0d", $realtime, want.kind,
                             pts_out.case_code);
                    errors++;
                end
            end
        end
    end

    // offer one word, called at a rising edge; returns at the accepting edge
    task automatic send_pair(t_seg_pair p, bit typed, t_closest want);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle) begin
            seg_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_in.valid <= 1'b1;
        {seg_in.seg1_start_x, seg_in.seg1_start_y, seg_in.seg1_start_z,
         seg_in.seg1_end_x, seg_in.seg1_end_y, seg_in.seg1_end_z,
         seg_in.seg2_start_x, seg_in.seg2_start_y, seg_in.seg2_start_z,
         seg_in.seg2_end_x, seg_in.seg2_end_y, seg_in.seg2_end_z} <= p;
        do begin
            @(negedge i_clk);
            taken = seg_in.ready;
            if (taken) pending_q.push_back(typed ? want : closest_points(p, tolerance));
            @(posedge i_clk);
        end while (!taken);
    endtask

    // tolerance write, only with the pipeline drained
    task automatic write_tolerance(logic [15:0] value);
        bit taken;
        seg_in.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.zero_tolerance <= value;
        do begin
            @(negedge i_clk);
            taken = cfg_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        cfg_ch.valid <= 1'b0;
        tolerance = value;
    endtask

    initial begin
        t_table_row  rows[$];
        logic [15:0] tol_plan[6];
        t_seg_pair   p;
        t_closest    none;

        none                  = '0;
        i_rst_n               = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.zero_tolerance = '0;
        seg_in.valid          = 1'b0;
        {seg_in.seg1_start_x, seg_in.seg1_start_y, seg_in.seg1_start_z,
         seg_in.seg1_end_x, seg_in.seg1_end_y, seg_in.seg1_end_z,
         seg_in.seg2_start_x, seg_in.seg2_start_y, seg_in.seg2_start_z,
         seg_in.seg2_end_x, seg_in.seg2_end_y, seg_in.seg2_end_z} = '0;
        tolerance = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, tolerance at its reset value of zero
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
                         points_only(0, 0, 0, 0, 0, 0)});
        rows.push_back('{'{1, 2, 3, 1, 2, 3, -1, -1, -1, -1, -1, -1}, 1'b1,
                         points_only(1, 2, 3, -1, -1, -1)});
        // identical full-range diagonals
        rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, -32768, -32768, 32767, 32767, 32767}, 1'b0, none});
        // full-range crossing diagonals, then identical reversed diagonals
        rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, -32768, 32767, -32768, 32767, -32768}, 1'b0, none});
        rows.push_back('{'{32767, 32767, 32767, -32768, -32768, -32768,
                           32767, 32767, 32767, -32768, -32768, -32768}, 1'b0, none});
        // parallel and collinear overlap
        rows.push_back('{'{0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 10, 0, 0, 4, 0, 0, 20, 0, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 10, 0, 0, 30, 3, 0, 20, 3, 0}, 1'b0, none});
        // first, then second segment a single point
        rows.push_back('{'{5, 5, 0, 5, 5, 0, 0, 0, 0, 10, 0, 0}, 1'b0, none});
        rows.push_back('{'{-5, 5, 0, -5, 5, 0, 0, 0, 0, 10, 0, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 10, 0, 0, 3, 7, 1, 3, 7, 1}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 10, 0, 0, 17, -2, 9, 17, -2, 9}, 1'b0, none});
        // perpendicular crossing, skew with both ends clamped
        rows.push_back('{'{-10, 0, 0, 10, 0, 0, 0, -10, 3, 0, 10, 3}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 1, 0, 0, 5, -3, 4, 7, -9, 2}, 1'b0, none});
        rows.push_back('{'{3, 1, 7, 9, 2, -4, -1, -1, -1, -6, 5, 2}, 1'b0, none});
        rows.push_back('{'{-32768, 0, 0, -32768, 1, 0, 32767, 0, 0, 32767, 0, 1}, 1'b0, none});
        foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want);

        // random phases across tolerance settings and idling patterns
        tol_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd30, 16'd0, 16'd0};
        tol_plan[5] = $urandom_range(0, 65535);
        for (int phase = 0; phase < 6; phase++) begin
            // phase four uses a small, near-degenerate tolerance
            if (phase == 4) tol_plan[4] = 16'd12;
            write_tolerance(tol_plan[phase]);
            case (phase % 3)
                0: begin
                    tx_idle = 30;
                    rx_idle = 71;
                end
                1: begin
                    tx_idle = 71;
                    rx_idle = 30;
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            if (phase == 2) begin
                @(negedge i_clk);
                hold_left = 300;
                @(posedge i_clk);
            end
            for (int n = 0; n < 130; n++) begin
                p = random_pair();
                send_pair(p, 1'b0, none);
            end
        end

        // drain
        seg_in.valid <= 1'b0;
        tx_idle = 0;
        rx_idle = 0;
        wait (pending_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ssc_pkg.sv
hdl/ssc_cfg_if.sv
hdl/ssc_in_if.sv
hdl/ssc_out_if.sv
hdl/ssc_div.sv
hdl/segment_segment_closest_points.sv
test/segment_segment_closest_points_test.sv
